// ----- design/nufs_pkg.sv -----
// ============================================================================
// nufs_pkg: shared types and constants for the text/binary frame splitter
// Item structs, frame mode and action codes, protocol bytes, helpers.
// ============================================================================
package nufs_pkg;

    // Protocol bytes
    localparam logic [7:0] TEXT_SYNC0 = 8'h24;   // '$'
    localparam logic [7:0] TEXT_SYNC1 = 8'h47;   // 'G'
    localparam logic [7:0] BIN_SYNC0  = 8'hB5;
    localparam logic [7:0] BIN_SYNC1  = 8'h62;
    localparam logic [7:0] LINE_FEED  = 8'h0A;
    localparam logic [23:0] GGA_CODE  = 24'h474741;

    localparam logic [7:0] CLS_RAW      = 8'h02;
    localparam logic [7:0] ID_RAW_MEAS  = 8'h15;
    localparam logic [7:0] ID_SUBFRAME  = 8'h13;
    localparam logic [7:0] CLS_NAV      = 8'h01;
    localparam logic [7:0] ID_NAV_SOL   = 8'h06;

    localparam int unsigned CNT_W = 17;
    localparam logic [CNT_W-1:0] COUNT_MAX   = 17'd65543;
    localparam logic [CNT_W-1:0] NAV_MAX_LEN = 17'd64;
    localparam logic [CNT_W-1:0] GGA_MAX_LEN = 17'd128;
    localparam logic [CNT_W-1:0] BIN_OVERHEAD = 17'd8;

    // Queue between classifier and frame engine
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_TEXT = 2'd1,
        MODE_BIN  = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_GGA      = 3'd1,
        ACT_RAW_MEAS = 3'd2,
        ACT_SUBFRAME = 3'd3,
        ACT_NAV_SOL  = 3'd4
    } t_action;

    // Classified byte handed from the front to the frame engine
    typedef struct packed {
        logic [7:0] data;
        logic       start_text;
        logic       start_bin;
    } t_cls_item;

    // Result item
    typedef struct packed {
        logic [7:0]       frame_byte;
        logic             frame_kind;
        logic             first_mark;
        logic             last_mark;
        logic [CNT_W-1:0] frame_length;
        t_action          action;
    } t_result;

    // Saturating count increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v >= COUNT_MAX) ? COUNT_MAX : v + 1'b1;
    endfunction

endpackage

// ----- design/nufs_front.sv -----
// ============================================================================
// nufs_front: byte holder and start-pair classifier
// Holds each byte until the next one (or a flush) arrives, then pushes the
// held byte with its start flags into the queue.
// ============================================================================
module nufs_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_kind,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_space,
    output logic               o_push,
    output nufs_pkg::t_cls_item o_item
);
    import nufs_pkg::*;

    logic       r_held_valid;
    logic [7:0] r_held_byte;
    logic       w_accept;

    assign o_ready  = i_space;
    assign w_accept = i_valid && i_space;

    // Classify the held byte against the incoming one
    assign o_push            = w_accept && r_held_valid;
    assign o_item.data       = r_held_byte;
    assign o_item.start_text = !i_kind && (r_held_byte == TEXT_SYNC0) &&
                               (i_rx_byte == TEXT_SYNC1);
    assign o_item.start_bin  = !i_kind && (r_held_byte == BIN_SYNC0) &&
                               (i_rx_byte == BIN_SYNC1);

    // Hold register: a byte replaces the held one, a flush empties it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
        end else if (w_accept) begin
            r_held_valid <= !i_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !i_kind) begin
            r_held_byte <= i_rx_byte;
        end
    end

endmodule

// ----- design/nufs_queue.sv -----
// ============================================================================
// nufs_queue: short queue of classified items
// Register-based FIFO between the classifier and the frame engine.
// ============================================================================
module nufs_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  nufs_pkg::t_cls_item i_item,
    output logic                o_space,
    output logic                o_valid,
    output nufs_pkg::t_cls_item o_item,
    input  logic                i_pop
);
    import nufs_pkg::*;

    t_cls_item           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                w_push;
    logic                w_pop;

    assign o_valid = (r_count != '0);
    assign o_space = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_space;
    assign w_pop   = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- design/nufs_back.sv -----
// ============================================================================
// nufs_back: frame engine
// Tracks text and binary frames, counts bytes, captures header fields and
// registers one result item per in-frame byte.
// ============================================================================
module nufs_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_raw_enable,
    input  logic                i_valid,
    input  nufs_pkg::t_cls_item i_item,
    output logic                o_pop,
    output logic                o_valid,
    output nufs_pkg::t_result   o_res,
    input  logic                i_ready
);
    import nufs_pkg::*;

    t_mode            r_mode, n_mode;
    logic [CNT_W-1:0] r_tcount, r_bcount;
    logic [23:0]      r_stype;
    logic [15:0]      r_dlen;
    logic             r_lk;
    logic [7:0]       r_class, r_id;
    logic             r_ov;
    t_result          r_res, n_res;

    t_mode            w_mode_eff;
    logic [7:0]       w_c;
    logic [CNT_W-1:0] w_tbase, w_bbase, w_tcnt_new, w_bcnt_new;
    logic [23:0]      w_stype_base, w_stype_new;
    logic [15:0]      w_dlen_base, w_dlen_new;
    logic             w_lk_new;
    logic [7:0]       w_class_new, w_id_new;
    logic             w_text_last, w_bin_last;
    t_action          w_text_act, w_bin_act;

    assign o_pop   = i_valid && (!r_ov || i_ready);
    assign o_valid = r_ov;
    assign o_res   = r_res;
    assign w_c     = i_item.data;

    // Effective mode: a start pair overrides the running frame
    always_comb begin
        if (i_item.start_bin) begin
            w_mode_eff = MODE_BIN;
        end else if (i_item.start_text) begin
            w_mode_eff = MODE_TEXT;
        end else begin
            w_mode_eff = r_mode;
        end
    end

    // Text datapath
    always_comb begin
        w_tbase      = i_item.start_text ? '0 : r_tcount;
        w_stype_base = i_item.start_text ? '0 : r_stype;
        w_stype_new  = w_stype_base;
        if (w_tbase == 17'd3) begin
            w_stype_new[23:16] = w_c;
        end else if (w_tbase == 17'd4) begin
            w_stype_new[15:8] = w_c;
        end else if (w_tbase == 17'd5) begin
            w_stype_new[7:0] = w_c;
        end
        w_tcnt_new  = sat_inc(w_tbase);
        w_text_last = (w_c == LINE_FEED);
        w_text_act  = ((w_stype_new == GGA_CODE) && (w_tcnt_new < GGA_MAX_LEN)) ?
                      ACT_GGA : ACT_NONE;
    end

    // Binary datapath
    always_comb begin
        w_bbase     = i_item.start_bin ? '0 : r_bcount;
        w_dlen_base = i_item.start_bin ? '0 : r_dlen;
        w_lk_new    = i_item.start_bin ? 1'b0 : r_lk;
        w_dlen_new  = w_dlen_base;
        w_class_new = r_class;
        w_id_new    = r_id;
        if (w_bbase == 17'd2) begin
            w_class_new = w_c;
        end else if (w_bbase == 17'd3) begin
            w_id_new = w_c;
        end else if (w_bbase == 17'd4) begin
            w_dlen_new[7:0] = w_c;
        end else if (w_bbase == 17'd5) begin
            w_dlen_new[15:8] = w_c;
            w_lk_new         = 1'b1;
        end
        w_bcnt_new = sat_inc(w_bbase);
        w_bin_last = w_lk_new && (w_bcnt_new == ({1'b0, w_dlen_new} + BIN_OVERHEAD));
        // Message selection by class and id
        w_bin_act = ACT_NONE;
        if (w_class_new == CLS_RAW) begin
            if (i_raw_enable && (w_id_new == ID_RAW_MEAS)) begin
                w_bin_act = ACT_RAW_MEAS;
            end else if (i_raw_enable && (w_id_new == ID_SUBFRAME)) begin
                w_bin_act = ACT_SUBFRAME;
            end
        end else if ((w_class_new == CLS_NAV) && (w_id_new == ID_NAV_SOL) &&
                     (w_bcnt_new <= NAV_MAX_LEN)) begin
            w_bin_act = ACT_NAV_SOL;
        end
    end

    // Next frame mode
    always_comb begin
        n_mode = r_mode;
        if (o_pop) begin
            unique case (w_mode_eff)
                MODE_TEXT: n_mode = w_text_last ? MODE_IDLE : MODE_TEXT;
                MODE_BIN:  n_mode = w_bin_last ? MODE_IDLE : MODE_BIN;
                default:   n_mode = MODE_IDLE;
            endcase
        end
    end

    // Result fields
    always_comb begin
        n_res            = '0;
        n_res.frame_byte = w_c;
        n_res.first_mark = i_item.start_text || i_item.start_bin;
        n_res.action     = ACT_NONE;
        unique case (w_mode_eff)
            MODE_TEXT: begin
                n_res.frame_kind   = 1'b0;
                n_res.last_mark    = w_text_last;
                n_res.frame_length = w_tcnt_new;
                n_res.action       = w_text_last ? w_text_act : ACT_NONE;
            end
            MODE_BIN: begin
                n_res.frame_kind   = 1'b1;
                n_res.last_mark    = w_bin_last;
                n_res.frame_length = w_bcnt_new;
                n_res.action       = w_bin_last ? w_bin_act : ACT_NONE;
            end
            default: begin
                n_res.frame_kind = 1'b0;
            end
        endcase
    end

    // Frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_tcount <= '0;
            r_bcount <= '0;
            r_stype  <= '0;
            r_dlen   <= '0;
            r_lk     <= 1'b0;
            r_class  <= '0;
            r_id     <= '0;
        end else begin
            r_mode <= n_mode;
            if (o_pop && (w_mode_eff == MODE_TEXT)) begin
                r_tcount <= w_tcnt_new;
                r_stype  <= w_stype_new;
            end
            if (o_pop && (w_mode_eff == MODE_BIN)) begin
                r_bcount <= w_bcnt_new;
                r_dlen   <= w_dlen_new;
                r_lk     <= w_lk_new;
                r_class  <= w_class_new;
                r_id     <= w_id_new;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (o_pop) begin
            r_ov <= (w_mode_eff != MODE_IDLE);
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

endmodule

// ----- design/nmea_ubx_frame_splitter.sv -----
// ============================================================================
// nmea_ubx_frame_splitter: text sentence / binary frame splitter
// Splits a receiver byte stream into '$G' text sentences and 0xB5 0x62
// binary frames, marking each in-frame byte and coding an action on the last.
// ============================================================================
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  input    | i_valid/o_ready, i_kind, i_rx_byte       | in
//  result   | o_valid/i_ready, o_frame_* , o_action    | out
//  config   | i_cfg_we, i_cfg_data (raw_enable)        | in
//
//  One item per cycle sustained while results are taken. A byte is held until
//  the next item, enters the two-entry queue at that accept edge, and lands in
//  the output register when the frame engine pops it from the queue.
//  Reset (synchronous, active low) empties the hold register, queue and
//  output register and returns the frame engine to idle; raw_enable clears.
//  A stalled result stops the engine; the queue then fills and drops o_ready.
//
module nmea_ubx_frame_splitter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_kind,
    input  logic [7:0]                 i_rx_byte,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [7:0]                 o_frame_byte,
    output logic                       o_frame_kind,
    output logic                       o_first_mark,
    output logic                       o_last_mark,
    output logic [nufs_pkg::CNT_W-1:0] o_frame_length,
    output logic [2:0]                 o_action,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_data
);
    import nufs_pkg::*;

    logic      r_raw_enable;
    logic      w_push, w_space, w_q_valid, w_pop;
    t_cls_item w_push_item, w_head_item;
    t_result   w_res;

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_enable <= 1'b0;
        end else if (i_cfg_we) begin
            r_raw_enable <= i_cfg_data;
        end
    end

    nufs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_kind    (i_kind),
        .i_rx_byte (i_rx_byte),
        .i_space   (w_space),
        .o_push    (w_push),
        .o_item    (w_push_item)
    );

    nufs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_space (w_space),
        .o_valid (w_q_valid),
        .o_item  (w_head_item),
        .i_pop   (w_pop)
    );

    nufs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_raw_enable (r_raw_enable),
        .i_valid      (w_q_valid),
        .i_item       (w_head_item),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .o_res        (w_res),
        .i_ready      (i_ready)
    );

    assign o_frame_byte   = w_res.frame_byte;
    assign o_frame_kind   = w_res.frame_kind;
    assign o_first_mark   = w_res.first_mark;
    assign o_last_mark    = w_res.last_mark;
    assign o_frame_length = w_res.frame_length;
    assign o_action       = w_res.action;

    // Actions only on the closing byte of a frame
    a_action_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_mark) |-> (o_action == ACT_NONE))
        else $error("action on a byte that does not end a frame");

    // A frame never opens and closes on the same byte
    a_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_first_mark) |-> !o_last_mark)
        else $error("frame opened and closed on one byte");

    // The opening byte counts as length one
    a_first_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_first_mark) |-> (o_frame_length == 17'd1))
        else $error("frame length not one on first byte");

    // A GGA action needs a text frame
    a_action_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_action == ACT_GGA)) |-> !o_frame_kind)
        else $error("text action on a binary frame");

endmodule

// ----- sim/nmea_ubx_frame_splitter_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// nmea_ubx_frame_splitter_tb: self-checking bench for the frame splitter
// Feeds text sentences, binary frames, noise and flushes with random pacing
// on both handshakes. A cycle-free model of the splitter predicts each
// in-frame byte, and results are compared field by field in order.
// ============================================================================
module nmea_ubx_frame_splitter_tb;
    import nufs_pkg::*;

    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;
    localparam logic FRAME_TEXT = 1'b0;
    localparam logic FRAME_BIN  = 1'b1;

    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned PHASE_ITEMS   = 300;
    localparam int unsigned MAX_REPORTS   = 40;

    typedef enum logic [1:0] {
        OP_BYTE,
        OP_CFG,
        OP_DRAIN
    } t_stim_op;

    typedef struct packed {
        t_stim_op   op;
        logic       kind;
        logic [7:0] data;
        logic       steady;
    } t_stim_item;

    // DUT ports
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_valid    = 1'b0;
    logic                  o_ready;
    logic                  i_kind     = 1'b0;
    logic [7:0]            i_rx_byte  = 8'h00;
    logic                  o_valid;
    logic                  i_ready    = 1'b0;
    logic [7:0]            o_frame_byte;
    logic                  o_frame_kind;
    logic                  o_first_mark;
    logic                  o_last_mark;
    logic [CNT_W-1:0]      o_frame_length;
    logic [2:0]            o_action;
    logic                  i_cfg_we   = 1'b0;
    logic                  i_cfg_data = 1'b0;

    // Stimulus and expectations
    t_stim_item  pending_items[$];
    t_result     due_frame_bytes[$];
    int unsigned stim_count   = 0;
    bit          gen_steady   = 1'b0;
    bit          in_taken     = 1'b0;
    int unsigned quiet_cycles = 0;
    int unsigned fail_count   = 0;

    // Pacing state
    int unsigned gap_left   = 0;
    int unsigned stall_left = 0;
    int unsigned burst_left = 0;
    bit          run_steady = 1'b0;

    // Splitter model state
    t_mode            fr_mode      = MODE_IDLE;
    logic [7:0]       fr_held_byte = 8'h00;
    bit               fr_held_ok   = 1'b0;
    logic [CNT_W-1:0] fr_text_len  = '0;
    logic [CNT_W-1:0] fr_bin_len   = '0;
    logic [15:0]      fr_decl_len  = '0;
    bit               fr_len_known = 1'b0;
    logic [23:0]      fr_sentence  = '0;
    logic [7:0]       fr_class     = '0;
    logic [7:0]       fr_id        = '0;
    bit               fr_raw_en    = 1'b0;

    nmea_ubx_frame_splitter DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_frame_byte   (o_frame_byte),
        .o_frame_kind   (o_frame_kind),
        .o_first_mark   (o_first_mark),
        .o_last_mark    (o_last_mark),
        .o_frame_length (o_frame_length),
        .o_action       (o_action),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Splitter model
    // ------------------------------------------------------------------
    function automatic logic [CNT_W-1:0] bump_count(input logic [CNT_W-1:0] v);
        return (v >= COUNT_MAX) ? COUNT_MAX : v + 1'b1;
    endfunction

    // Classify one held byte; returns 1 when it belongs to a frame
    function automatic bit classify_byte(input logic [7:0] c, input bit has_next,
                                         input logic [7:0] nxt, output t_result r);
        bit is_first;
        bit is_last;
        is_first = 1'b0;
        is_last  = 1'b0;
        r = '0;
        if (has_next && c == TEXT_SYNC0 && nxt == TEXT_SYNC1) begin
            fr_mode     = MODE_TEXT;
            fr_text_len = '0;
            fr_sentence = '0;
            is_first    = 1'b1;
        end
        if (has_next && c == BIN_SYNC0 && nxt == BIN_SYNC1) begin
            fr_mode      = MODE_BIN;
            fr_bin_len   = '0;
            fr_len_known = 1'b0;
            fr_decl_len  = '0;
            is_first     = 1'b1;
        end
        case (fr_mode)
            MODE_TEXT: begin
                // sentence type sits at bytes 3..5
                case (fr_text_len)
                    3: fr_sentence[23:16] = c;
                    4: fr_sentence[15:8]  = c;
                    5: fr_sentence[7:0]   = c;
                    default: ;
                endcase
                fr_text_len    = bump_count(fr_text_len);
                r.frame_length = fr_text_len;
                r.frame_kind   = FRAME_TEXT;
                if (c == LINE_FEED) begin
                    is_last = 1'b1;
                    if (fr_sentence == GGA_CODE && fr_text_len < GGA_MAX_LEN)
                        r.action = ACT_GGA;
                    fr_mode = MODE_IDLE;
                end
            end
            MODE_BIN: begin
                // class, id and little-endian length follow the sync pair
                case (fr_bin_len)
                    2: fr_class = c;
                    3: fr_id    = c;
                    4: fr_decl_len[7:0] = c;
                    5: begin
                        fr_decl_len[15:8] = c;
                        fr_len_known      = 1'b1;
                    end
                    default: ;
                endcase
                fr_bin_len     = bump_count(fr_bin_len);
                r.frame_length = fr_bin_len;
                r.frame_kind   = FRAME_BIN;
                if (fr_len_known && fr_bin_len == {1'b0, fr_decl_len} + BIN_OVERHEAD) begin
                    is_last = 1'b1;
                    if (fr_class == CLS_RAW) begin
                        if (fr_raw_en) begin
                            if (fr_id == ID_RAW_MEAS)
                                r.action = ACT_RAW_MEAS;
                            else if (fr_id == ID_SUBFRAME)
                                r.action = ACT_SUBFRAME;
                        end
                    end else if (fr_class == CLS_NAV && fr_id == ID_NAV_SOL &&
                                 fr_bin_len <= NAV_MAX_LEN) begin
                        r.action = ACT_NAV_SOL;
                    end
                    fr_mode = MODE_IDLE;
                end
            end
            default: return 1'b0;
        endcase
        r.frame_byte = c;
        r.first_mark = is_first;
        r.last_mark  = is_last;
        return 1'b1;
    endfunction

    // One accepted item: process the held byte with or without lookahead
    function automatic bit stream_step(input logic kind, input logic [7:0] b,
                                       output t_result r);
        bit hit;
        hit = 1'b0;
        r   = '0;
        if (kind == KIND_BYTE) begin
            if (fr_held_ok)
                hit = classify_byte(fr_held_byte, 1'b1, b, r);
            fr_held_byte = b;
            fr_held_ok   = 1'b1;
        end else begin
            if (fr_held_ok)
                hit = classify_byte(fr_held_byte, 1'b0, 8'h00, r);
            fr_held_ok = 1'b0;
        end
        return hit;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] b);
        t_stim_item it;
        it.op     = OP_BYTE;
        it.kind   = KIND_BYTE;
        it.data   = b;
        it.steady = gen_steady;
        pending_items = {pending_items, it};
        stim_count++;
    endtask

    task automatic queue_flush();
        t_stim_item it;
        it.op     = OP_BYTE;
        it.kind   = KIND_FLUSH;
        it.data   = 8'($urandom_range(0, 255));
        it.steady = gen_steady;
        pending_items = {pending_items, it};
        stim_count++;
    endtask

    task automatic queue_ctrl(input t_stim_op op, input logic v);
        t_stim_item it;
        it.op     = op;
        it.kind   = KIND_BYTE;
        it.data   = {7'd0, v};
        it.steady = 1'b0;
        pending_items = {pending_items, it};
    endtask

    // '$','G', talker letter, 3-byte type, body, optional newline
    task automatic queue_sentence(input logic [23:0] code, input int body, input bit ended);
        logic [7:0] c;
        queue_byte(TEXT_SYNC0);
        queue_byte(TEXT_SYNC1);
        queue_byte(8'($urandom_range(8'h41, 8'h5A)));
        queue_byte(code[23:16]);
        queue_byte(code[15:8]);
        queue_byte(code[7:0]);
        repeat (body) begin
            c = 8'($urandom_range(0, 255));
            if (c == LINE_FEED)
                c = 8'h2C;
            queue_byte(c);
        end
        if (ended)
            queue_byte(LINE_FEED);
    endtask

    // Binary frame, cut after 'sent' bytes
    task automatic queue_ubx(input logic [7:0] cls, input logic [7:0] id,
                             input logic [15:0] len, input int sent);
        int i;
        for (i = 0; i < int'(len) + 8 && i < sent; i++) begin
            case (i)
                0: queue_byte(BIN_SYNC0);
                1: queue_byte(BIN_SYNC1);
                2: queue_byte(cls);
                3: queue_byte(id);
                4: queue_byte(len[7:0]);
                5: queue_byte(len[15:8]);
                default: queue_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    function automatic int unsigned pause_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    task automatic check_field(input string name, input logic [16:0] want,
                               input logic [16:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t ns: %s mismatch: expected %0d, actual %0d",
                         $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: new inputs at the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : feed_bytes
        logic       nxt_valid;
        logic       nxt_kind;
        logic [7:0] nxt_byte;
        logic       nxt_we;
        logic       nxt_cfg;
        logic       nxt_ready;
        nxt_valid = i_valid && !in_taken;
        nxt_kind  = i_kind;
        nxt_byte  = i_rx_byte;
        nxt_we    = 1'b0;
        nxt_cfg   = i_cfg_data;
        nxt_ready = i_ready;
        if (i_rst_n) begin
            // occasional stretches with no idling at all
            if (burst_left > 0)
                burst_left--;
            else if ($urandom_range(0, 99) < 2)
                burst_left = $urandom_range(40, 200);

            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() > 0) begin
                    case (pending_items[0].op)
                        OP_BYTE: begin
                            nxt_valid  = 1'b1;
                            nxt_kind   = pending_items[0].kind;
                            nxt_byte   = pending_items[0].data;
                            run_steady = pending_items[0].steady;
                            if (run_steady || burst_left > 0 || $urandom_range(0, 1))
                                gap_left = 0;
                            else
                                gap_left = pause_length();
                            void'(pending_items.pop_front());
                        end
                        OP_CFG: begin
                            if (quiet_cycles >= SETTLE_CYCLES) begin
                                nxt_we  = 1'b1;
                                nxt_cfg = pending_items[0].data[0];
                                void'(pending_items.pop_front());
                            end
                        end
                        default: begin
                            // hold off until every result is back
                            if (quiet_cycles >= SETTLE_CYCLES)
                                void'(pending_items.pop_front());
                        end
                    endcase
                end
            end

            // result-side back pressure
            if (run_steady || burst_left > 0) begin
                nxt_ready  = 1'b1;
                stall_left = 0;
            end else if (stall_left > 0) begin
                nxt_ready = 1'b0;
                stall_left--;
            end else begin
                nxt_ready = 1'b1;
                if ($urandom_range(0, 99) < 15)
                    stall_left = pause_length();
            end
        end
        i_valid    <= nxt_valid;
        i_kind     <= nxt_kind;
        i_rx_byte  <= nxt_byte;
        i_cfg_we   <= nxt_we;
        i_cfg_data <= nxt_cfg;
        i_ready    <= nxt_ready;
    end

    // ------------------------------------------------------------------
    // Monitor: handshakes sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_frames
        t_result want;
        t_result r;
        if (i_rst_n) begin
            // compare an accepted result with the oldest expectation
            if (o_valid && i_ready) begin
                if (due_frame_bytes.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t ns: unexpected result: expected none, actual byte %0d",
                                 $time, o_frame_byte);
                end else begin
                    want = due_frame_bytes.pop_front();
                    check_field("frame_byte", 17'(want.frame_byte), 17'(o_frame_byte));
                    check_field("frame_kind", 17'(want.frame_kind), 17'(o_frame_kind));
                    check_field("first_mark", 17'(want.first_mark), 17'(o_first_mark));
                    check_field("last_mark", 17'(want.last_mark), 17'(o_last_mark));
                    check_field("frame_length", want.frame_length, o_frame_length);
                    check_field("action", 17'(want.action), 17'(o_action));
                end
            end
            // predict from an accepted item
            if (i_valid && o_ready) begin
                if (stream_step(i_kind, i_rx_byte, r))
                    due_frame_bytes = {due_frame_bytes, r};
            end
            if (i_cfg_we)
                fr_raw_en = i_cfg_data;
            in_taken <= i_valid && o_ready;
            if (due_frame_bytes.size() == 0 && !i_valid && !i_cfg_we)
                quiet_cycles <= quiet_cycles + 1;
            else
                quiet_cycles <= 0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : stimulus
        int          phase;
        int unsigned stop_at;
        int unsigned r;
        int          k;
        logic [7:0]  cls;
        logic [7:0]  id;
        logic [15:0] len;
        logic [23:0] code;

        // Directed: flush with nothing held, idle bytes, GGA, short and
        // interrupted sentences, raw measurement frame, final flush
        queue_ctrl(OP_CFG, 1'b1);
        queue_flush();
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_sentence(GGA_CODE, 0, 1'b1);
        queue_byte(TEXT_SYNC0);
        queue_byte(TEXT_SYNC1);
        queue_byte(LINE_FEED);
        queue_byte(TEXT_SYNC0);
        queue_byte(TEXT_SYNC1);
        queue_byte(8'h50);
        queue_ubx(CLS_RAW, ID_RAW_MEAS, 16'd0, 8);
        queue_flush();
        queue_ctrl(OP_DRAIN, 1'b0);

        // Back-to-back stretch: no gaps on input, no stalls on results
        gen_steady = 1'b1;
        queue_sentence(GGA_CODE, 10, 1'b1);
        queue_ubx(CLS_NAV, ID_NAV_SOL, 16'd4, 12);
        queue_byte(8'h55);
        queue_flush();
        gen_steady = 1'b0;

        // Random phases, raw_enable toggled between them
        for (phase = 0; phase < 6; phase++) begin
            queue_ctrl(OP_CFG, 1'(phase % 2));
            stop_at = stim_count + PHASE_ITEMS;
            while (stim_count < stop_at) begin
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    if ($urandom_range(0, 9) == 0) begin
                        // sentence too short to hold a type
                        queue_byte(TEXT_SYNC0);
                        queue_byte(TEXT_SYNC1);
                        repeat ($urandom_range(0, 3))
                            queue_byte(8'($urandom_range(8'h41, 8'h5A)));
                        queue_byte(LINE_FEED);
                    end else begin
                        if ($urandom_range(0, 9) < 4)
                            code = GGA_CODE;
                        else
                            code = {8'($urandom_range(8'h41, 8'h5A)),
                                    8'($urandom_range(8'h41, 8'h5A)),
                                    8'($urandom_range(8'h41, 8'h5A))};
                        k = $urandom_range(0, 99);
                        if (k < 80)
                            k = $urandom_range(0, 20);
                        else
                            k = $urandom_range(112, 124);
                        queue_sentence(code, k, $urandom_range(0, 9) != 0);
                    end
                end else if (r < 75) begin
                    case ($urandom_range(0, 5))
                        0: begin cls = CLS_RAW; id = ID_RAW_MEAS; end
                        1: begin cls = CLS_RAW; id = ID_SUBFRAME; end
                        2: begin cls = CLS_RAW; id = 8'($urandom_range(0, 255)); end
                        3: begin cls = CLS_NAV; id = ID_NAV_SOL; end
                        4: begin cls = CLS_NAV; id = 8'($urandom_range(0, 255)); end
                        default: begin
                            cls = 8'($urandom_range(0, 255));
                            id  = 8'($urandom_range(0, 255));
                        end
                    endcase
                    k = $urandom_range(0, 99);
                    if (k < 75)
                        len = 16'($urandom_range(0, 16));
                    else if (k < 95)
                        len = 16'($urandom_range(50, 62));
                    else
                        len = 16'($urandom_range(100, 200));
                    if ($urandom_range(0, 9) == 0)
                        queue_ubx(cls, id, len, $urandom_range(1, int'(len) + 7));
                    else
                        queue_ubx(cls, id, len, int'(len) + 8);
                end else if (r < 90) begin
                    repeat ($urandom_range(1, 6)) queue_byte(8'($urandom_range(0, 255)));
                end else begin
                    queue_flush();
                end
                if ($urandom_range(0, 99) < 8)
                    queue_flush();
            end
            queue_flush();
        end

        // release reset
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait for the stimulus to drain and the block to go quiet
        while (!(pending_items.size() == 0 && !i_valid && due_frame_bytes.size() == 0 &&
                 quiet_cycles >= SETTLE_CYCLES))
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && due_frame_bytes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
